// ===== rtl/core/rotate_offset_kalman_position_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rotate-offset Kalman position block
// Each macro expands to a labeled concurrent assertion, or to nothing when
// assertions are switched off for the build.
// ----------------------------------------------------------------------------
`ifndef ROTATE_OFFSET_KALMAN_POSITION_DEFINES_SVH
`define ROTATE_OFFSET_KALMAN_POSITION_DEFINES_SVH

`ifndef ASSERT_OFF
`define ROKP_ASSERT_IMP(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rokp: assertion failed");
`define ROKP_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rokp: assertion failed");
`else
`define ROKP_ASSERT_IMP(name, clk, rstn, ante, cons)
`define ROKP_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/core/rokp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rotate-offset Kalman position package
// Register indexes, reset values and fixed widths of the position block.
// ----------------------------------------------------------------------------
package rokp_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int COEF_W    = 16;
    localparam int VAR_W     = 24;
    localparam int ROT_FRAC  = 14;
    localparam int GAIN_FRAC = 16;
    localparam int ROT_HALF  = 1 << (ROT_FRAC - 1);
    localparam int GAIN_HALF = 1 << (GAIN_FRAC - 1);

    // One step per multiplier bit: the sign-extended coefficients and the gain are 17 bits wide.
    localparam int MUL_STEPS = GAIN_FRAC + 1;
    localparam int CNT_W     = 5;

    typedef logic [VAR_W-1:0]     var_t;
    typedef logic [COEF_W-1:0]    coef_t;
    typedef logic [GAIN_FRAC:0]   gain_t;
    typedef logic [CNT_W-1:0]     step_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam step_t LAST_STEP = step_t'(MUL_STEPS - 1);
    localparam gain_t GAIN_ONE  = gain_t'(1 << GAIN_FRAC);
    localparam var_t  VAR_MAX   = '1;

    localparam cfg_idx_t REG_FILTER_EN  = 3'd0;
    localparam cfg_idx_t REG_ROT_COS    = 3'd1;
    localparam cfg_idx_t REG_ROT_SIN    = 3'd2;
    localparam cfg_idx_t REG_ORIGIN_X   = 3'd3;
    localparam cfg_idx_t REG_ORIGIN_Y   = 3'd4;
    localparam cfg_idx_t REG_PROC_NOISE = 3'd5;
    localparam cfg_idx_t REG_MEAS_NOISE = 3'd6;

    localparam coef_t COS_RESET        = 16'd16384;
    localparam var_t  PROC_NOISE_RESET = 24'd655;
    localparam var_t  MEAS_NOISE_RESET = 24'd6554;
    localparam var_t  INIT_VAR_RESET   = 24'd6554;

endpackage
`default_nettype wire

// ===== rtl/core/rotate_offset_kalman_position.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rotate-offset Kalman position filter
// Turns a local x,y position into north and east offsets about a configured
// origin and heading, with optional scalar Kalman smoothing on both axes.
// ----------------------------------------------------------------------------
// The block takes one position at a time. A position is transferred when
// in_valid is high and in_stall is low; in_stall stays high until the result
// has been placed in the output register, which holds it until the
// downstream side takes it, so a new position may enter while the previous
// result still waits. With filtering on, a position goes through two passes
// of 17 steps each through the bit-serial shift-and-add datapath; with
// filtering off, only through the first. The first pass rotates the position
// while the restoring divider forms the gain one quotient bit per step, the
// second applies the gain to both estimates and the variance. The initial
// variance register takes effect only at reset, where it always holds its
// reset value, so writes to it have no effect.
`include "rotate_offset_kalman_position_defines.svh"

module rotate_offset_kalman_position #(
    parameter int POS_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [rokp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [((POS_WIDTH > rokp_pkg::VAR_W) ? POS_WIDTH : rokp_pkg::VAR_W)-1:0]
                                              cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [POS_WIDTH-1:0]       pos_x,
    input  logic signed [POS_WIDTH-1:0]       pos_y,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [POS_WIDTH-1:0]       north,
    output logic signed [POS_WIDTH-1:0]       east
);

    import rokp_pkg::*;

    localparam int W  = POS_WIDTH;
    localparam int DW = W + 1;
    localparam int SW = W + 2;
    localparam int AW = W + 19;
    localparam int QW = W + 5;
    localparam int VW = 42;
    localparam int PW = VAR_W + 1;
    localparam int NW = VAR_W + 2;
    localparam int RW = VAR_W + 3;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_ROT  = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_DIF  = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    localparam logic signed [QW-1:0] SAT_HI = {6'b000000, {(W-1){1'b1}}};
    localparam logic signed [QW-1:0] SAT_LO = {6'b111111, {(W-1){1'b0}}};

    function automatic logic [W-1:0] sat_pos(input logic signed [QW-1:0] v);
        logic [W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[W-1:0];
        end else begin
            r = v[W-1:0];
        end
        return r;
    endfunction

    // Configuration registers.
    logic          filter_en_reg;
    coef_t         cos_reg;
    coef_t         sin_reg;
    logic [W-1:0]  origin_x_reg;
    logic [W-1:0]  origin_y_reg;
    var_t          proc_noise_reg;
    var_t          meas_noise_reg;

    // Control and filter state.
    logic [2:0]    state_reg, state_next;
    step_t         cnt_reg, cnt_next;
    logic          out_valid_reg, out_valid_next;
    logic [W-1:0]  north_est_reg, north_est_next;
    logic [W-1:0]  east_est_reg, east_est_next;
    var_t          err_var_reg, err_var_next;

    // Datapath.
    logic [DW-1:0] dx_reg, dx_next;
    logic [DW-1:0] dy_reg, dy_next;
    logic [SW-1:0] dsum_reg, dsum_next;
    logic [AW-1:0] acc_n_reg, acc_n_next;
    logic [AW-1:0] acc_e_reg, acc_e_next;
    logic [VW-1:0] acc_v_reg, acc_v_next;
    gain_t         ma_reg, ma_next;
    gain_t         mb_reg, mb_next;
    gain_t         mc_reg, mc_next;
    logic [RW-1:0] rem_reg, rem_next;
    gain_t         q_reg, q_next;
    logic [PW-1:0] p_reg, p_next;
    logic [NW-1:0] den_reg, den_next;
    gain_t         gain_reg, gain_next;
    logic [W-1:0]  rn_reg, rn_next;
    logic [W-1:0]  re_reg, re_next;
    logic [W-1:0]  north_reg, north_next;
    logic [W-1:0]  east_reg, east_next;

    logic          rot;
    logic          first;
    logic          out_load;
    logic [1:0]    n_code, e_code;
    logic [SW-1:0] n_pick, e_pick;
    logic [AW-1:0] n_term, e_term, n_add, e_add, n_base, e_base;
    logic [VW-1:0] v_base, v_add, v_rnd;
    logic [NW-1:0] v_new;
    logic [RW-1:0] trial;
    logic          ge;
    logic [PW-1:0] p_sum;
    logic [NW-1:0] den_sum;
    gain_t         cos17, sin17;
    logic [AW-1:0] rot_rnd_n, rot_rnd_e, kal_rnd_n, kal_rnd_e;
    logic [QW-1:0] kal_sum_n, kal_sum_e;
    logic [W+2:0]  kal_d_n, kal_d_e;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign north     = north_reg;
    assign east      = east_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_en_reg  <= 1'b1;
            cos_reg        <= COS_RESET;
            sin_reg        <= '0;
            origin_x_reg   <= '0;
            origin_y_reg   <= '0;
            proc_noise_reg <= PROC_NOISE_RESET;
            meas_noise_reg <= MEAS_NOISE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FILTER_EN:  filter_en_reg  <= cfg_data[0];
                REG_ROT_COS:    cos_reg        <= cfg_data[COEF_W-1:0];
                REG_ROT_SIN:    sin_reg        <= cfg_data[COEF_W-1:0];
                REG_ORIGIN_X:   origin_x_reg   <= cfg_data[W-1:0];
                REG_ORIGIN_Y:   origin_y_reg   <= cfg_data[W-1:0];
                REG_PROC_NOISE: proc_noise_reg <= cfg_data[VAR_W-1:0];
                REG_MEAS_NOISE: meas_noise_reg <= cfg_data[VAR_W-1:0];
                default:        ;
            endcase
        end
    end

    assign rot   = (state_reg == ST_ROT);
    assign first = (cnt_reg == '0);
    assign cos17 = {cos_reg[COEF_W-1], cos_reg};
    assign sin17 = {sin_reg[COEF_W-1], sin_reg};

    // North takes cos on dx and -sin on dy; east takes sin on dx and cos on dy.
    // In the gain pass both use the gain bit on their own difference.
    assign n_code = rot ? {ma_reg[GAIN_FRAC], mc_reg[GAIN_FRAC]} : {ma_reg[GAIN_FRAC], 1'b0};
    assign e_code = rot ? {mb_reg[GAIN_FRAC], ma_reg[GAIN_FRAC]} : {1'b0, ma_reg[GAIN_FRAC]};

    always_comb
    begin
        case (n_code)
            2'b10:   n_pick = {dx_reg[DW-1], dx_reg};
            2'b01:   n_pick = {dy_reg[DW-1], dy_reg};
            2'b11:   n_pick = dsum_reg;
            default: n_pick = '0;
        endcase
        case (e_code)
            2'b10:   e_pick = {dx_reg[DW-1], dx_reg};
            2'b01:   e_pick = {dy_reg[DW-1], dy_reg};
            2'b11:   e_pick = dsum_reg;
            default: e_pick = '0;
        endcase
    end

    assign n_term = {{(AW-SW){n_pick[SW-1]}}, n_pick};
    assign e_term = {{(AW-SW){e_pick[SW-1]}}, e_pick};
    assign n_add  = (rot && first) ? (AW'(0) - n_term) : n_term;
    assign e_add  = (rot && first) ? (AW'(0) - e_term) : e_term;
    assign n_base = first ? '0 : {acc_n_reg[AW-2:0], 1'b0};
    assign e_base = first ? '0 : {acc_e_reg[AW-2:0], 1'b0};

    assign v_base = first ? '0 : {acc_v_reg[VW-2:0], 1'b0};
    assign v_add  = mb_reg[GAIN_FRAC] ? {{(VW-PW){1'b0}}, p_reg} : '0;
    assign v_rnd  = acc_v_reg + VW'(GAIN_HALF);
    assign v_new  = v_rnd[VW-1:GAIN_FRAC];

    assign trial = first ? rem_reg : {rem_reg[RW-2:0], 1'b0};
    assign ge    = (trial >= {1'b0, den_reg});

    assign p_sum   = {1'b0, err_var_reg} + {1'b0, proc_noise_reg};
    assign den_sum = {1'b0, p_sum} + {2'b00, meas_noise_reg};

    assign rot_rnd_n = acc_n_reg + AW'(ROT_HALF);
    assign rot_rnd_e = acc_e_reg + AW'(ROT_HALF);
    assign kal_rnd_n = acc_n_reg + AW'(GAIN_HALF);
    assign kal_rnd_e = acc_e_reg + AW'(GAIN_HALF);
    assign kal_d_n   = kal_rnd_n[AW-1:GAIN_FRAC];
    assign kal_d_e   = kal_rnd_e[AW-1:GAIN_FRAC];
    assign kal_sum_n = {{5{north_est_reg[W-1]}}, north_est_reg} + {{2{kal_d_n[W+2]}}, kal_d_n};
    assign kal_sum_e = {{5{east_est_reg[W-1]}}, east_est_reg} + {{2{kal_d_e[W+2]}}, kal_d_e};

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        north_est_next = north_est_reg;
        east_est_next  = east_est_reg;
        err_var_next   = err_var_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        dsum_next      = dsum_reg;
        acc_n_next     = acc_n_reg;
        acc_e_next     = acc_e_reg;
        acc_v_next     = acc_v_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        mc_next        = mc_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        p_next         = p_reg;
        den_next       = den_reg;
        gain_next      = gain_reg;
        rn_next        = rn_reg;
        re_next        = re_reg;
        north_next     = north_reg;
        east_next      = east_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dx_next    = {pos_x[W-1], pos_x} - {origin_x_reg[W-1], origin_x_reg};
                    dy_next    = {origin_y_reg[W-1], origin_y_reg} - {pos_y[W-1], pos_y};
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                dsum_next  = {dx_reg[DW-1], dx_reg} + {dy_reg[DW-1], dy_reg};
                p_next     = p_sum;
                den_next   = den_sum;
                rem_next   = {2'b00, p_sum};
                ma_next    = cos17;
                mb_next    = sin17;
                mc_next    = gain_t'(0) - sin17;
                cnt_next   = '0;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                acc_n_next = n_base + n_add;
                acc_e_next = e_base + e_add;
                rem_next   = ge ? (trial - {1'b0, den_reg}) : trial;
                q_next     = {q_reg[GAIN_FRAC-1:0], ge};
                ma_next    = {ma_reg[GAIN_FRAC-1:0], 1'b0};
                mb_next    = {mb_reg[GAIN_FRAC-1:0], 1'b0};
                mc_next    = {mc_reg[GAIN_FRAC-1:0], 1'b0};
                cnt_next   = cnt_reg + step_t'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                rn_next    = sat_pos(rot_rnd_n[AW-1:ROT_FRAC]);
                re_next    = sat_pos(rot_rnd_e[AW-1:ROT_FRAC]);
                // Error, process and measurement variances all zero means a zero denominator, and the gain is zero.
                gain_next  = (den_reg == '0) ? '0 : q_reg;
                state_next = filter_en_reg ? ST_DIF : ST_OUT;
            end
            ST_DIF:
            begin
                dx_next    = {rn_reg[W-1], rn_reg} - {north_est_reg[W-1], north_est_reg};
                dy_next    = {re_reg[W-1], re_reg} - {east_est_reg[W-1], east_est_reg};
                ma_next    = gain_reg;
                mb_next    = GAIN_ONE - gain_reg;
                cnt_next   = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                acc_n_next = n_base + n_add;
                acc_e_next = e_base + e_add;
                acc_v_next = v_base + v_add;
                ma_next    = {ma_reg[GAIN_FRAC-1:0], 1'b0};
                mb_next    = {mb_reg[GAIN_FRAC-1:0], 1'b0};
                cnt_next   = cnt_reg + step_t'(1);
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                north_est_next = sat_pos(kal_sum_n);
                east_est_next  = sat_pos(kal_sum_e);
                err_var_next   = (v_new > {2'b00, VAR_MAX}) ? VAR_MAX : v_new[VAR_W-1:0];
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    north_next     = filter_en_reg ? north_est_reg : rn_reg;
                    east_next      = filter_en_reg ? east_est_reg : re_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            north_est_reg <= '0;
            east_est_reg  <= '0;
            err_var_reg   <= INIT_VAR_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            north_est_reg <= north_est_next;
            east_est_reg  <= east_est_next;
            err_var_reg   <= err_var_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        dsum_reg  <= dsum_next;
        acc_n_reg <= acc_n_next;
        acc_e_reg <= acc_e_next;
        acc_v_reg <= acc_v_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        mc_reg    <= mc_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        p_reg     <= p_next;
        den_reg   <= den_next;
        gain_reg  <= gain_next;
        rn_reg    <= rn_next;
        re_reg    <= re_next;
        north_reg <= north_next;
        east_reg  <= east_next;
    end

    `ROKP_ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, in_valid && !in_stall, in_stall)
    `ROKP_ASSERT_IMP(a_result_from_out, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_OUT)
    `ROKP_ASSERT_NEXT(a_state_only_in_fin, clk, rst_n, state_reg != ST_FIN, $stable(north_est_reg) && $stable(east_est_reg) && $stable(err_var_reg))
    `ROKP_ASSERT_IMP(a_gain_range, clk, rst_n, state_reg == ST_DIF, gain_reg <= GAIN_ONE)
    `ROKP_ASSERT_IMP(a_step_range, clk, rst_n, state_reg == ST_ROT || state_reg == ST_MUL, cnt_reg <= LAST_STEP)

endmodule
`default_nettype wire

// ===== bench/tb_rotate_offset_kalman_position.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rotate-offset Kalman position testbench
// Sends local x,y positions through the block and checks every north/east
// result against a cycle-independent model of the rotation, the offset and
// the per-axis Kalman smoother. It covers directed corner cases and random
// traffic under several configurations, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_rotate_offset_kalman_position;
    import rokp_pkg::*;

    localparam int POS_W = 32;
    localparam int RUN_LIMIT = 2000000;
    localparam int SETTLE_CYCLES = 45;
    localparam int MAX_SHOWN = 10;
    localparam cfg_idx_t REG_INIT_VAR = 3'd7;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef struct packed {
        pos_t north;
        pos_t east;
    } nav_fix_t;

    localparam pos_t POS_HI = pos_t'(32'h7fff_ffff);
    localparam pos_t POS_LO = pos_t'(32'h8000_0000);
    localparam longint POS_HI_L = longint'(POS_HI);
    localparam longint POS_LO_L = longint'(POS_LO);

    logic     clk;
    logic     rst_n = 1'b0;
    logic     cfg_write = 1'b0;
    cfg_idx_t cfg_index = '0;
    logic [POS_W-1:0] cfg_data = '0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    pos_t     pos_x = '0;
    pos_t     pos_y = '0;
    logic     out_valid;
    logic     out_stall = 1'b0;
    pos_t     north;
    pos_t     east;

    logic  smooth_on = 1'b1;
    coef_t heading_cos = COS_RESET;
    coef_t heading_sin = '0;
    pos_t  origin_x_r = '0;
    pos_t  origin_y_r = '0;
    var_t  proc_var = PROC_NOISE_RESET;
    var_t  meas_var = MEAS_NOISE_RESET;
    var_t  err_var = INIT_VAR_RESET;
    pos_t  north_est = '0;
    pos_t  east_est = '0;

    nav_fix_t expected_fixes[$];
    nav_fix_t want_fix;

    int src_idle_pct = 32;
    int sink_stall_pct = 79;
    int errors = 0;
    int positions_sent = 0;
    int smoothed = 0;
    int fixes_checked = 0;
    int reg_writes = 0;

    rotate_offset_kalman_position #(
        .POS_WIDTH(POS_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .north(north),
        .east(east)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic pos_t clamp_pos(input longint v);
        if (v > POS_HI_L)
            return POS_HI;
        if (v < POS_LO_L)
            return POS_LO;
        return pos_t'(v);
    endfunction

    function automatic nav_fix_t track_fix(input pos_t x, input pos_t y);
        longint   dx;
        longint   dy;
        longint   p;
        longint   den;
        longint   gain;
        longint   nv;
        pos_t     rot_n;
        pos_t     rot_e;
        nav_fix_t fix;
        dx = longint'(x) - longint'(origin_x_r);
        dy = longint'(origin_y_r) - longint'(y);
        rot_n = clamp_pos((longint'($signed(heading_cos)) * dx
            - longint'($signed(heading_sin)) * dy + ROT_HALF) >>> ROT_FRAC);
        rot_e = clamp_pos((longint'($signed(heading_sin)) * dx
            + longint'($signed(heading_cos)) * dy + ROT_HALF) >>> ROT_FRAC);
        if (smooth_on)
        begin
            p = longint'(err_var) + longint'(proc_var);
            den = p + longint'(meas_var);
            gain = (den == 0) ? 0 : (p <<< GAIN_FRAC) / den;
            north_est = clamp_pos(longint'(north_est)
                + (((longint'(rot_n) - longint'(north_est)) * gain + GAIN_HALF) >>> GAIN_FRAC));
            east_est = clamp_pos(longint'(east_est)
                + (((longint'(rot_e) - longint'(east_est)) * gain + GAIN_HALF) >>> GAIN_FRAC));
            nv = (((longint'(1) <<< GAIN_FRAC) - gain) * p + GAIN_HALF) >>> GAIN_FRAC;
            err_var = (nv > longint'(VAR_MAX)) ? VAR_MAX : var_t'(nv);
            rot_n = north_est;
            rot_e = east_est;
        end
        fix.north = rot_n;
        fix.east = rot_e;
        return fix;
    endfunction

    task automatic write_reg(input cfg_idx_t idx, input logic [POS_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_FILTER_EN:  smooth_on = value[0];
            REG_ROT_COS:    heading_cos = value[COEF_W-1:0];
            REG_ROT_SIN:    heading_sin = value[COEF_W-1:0];
            REG_ORIGIN_X:   origin_x_r = value;
            REG_ORIGIN_Y:   origin_y_r = value;
            REG_PROC_NOISE: proc_var = value[VAR_W-1:0];
            REG_MEAS_NOISE: meas_var = value[VAR_W-1:0];
            default:        ;
        endcase
        reg_writes++;
        @(posedge clk);
    endtask

    task automatic set_all(input logic en, input coef_t c, input coef_t s,
                           input pos_t ox, input pos_t oy,
                           input var_t pn, input var_t mn, input var_t iv);
        write_reg(REG_FILTER_EN, {{(POS_W-1){1'b0}}, en});
        write_reg(REG_ROT_COS, {{(POS_W-COEF_W){1'b0}}, c});
        write_reg(REG_ROT_SIN, {{(POS_W-COEF_W){1'b0}}, s});
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_PROC_NOISE, {{(POS_W-VAR_W){1'b0}}, pn});
        write_reg(REG_MEAS_NOISE, {{(POS_W-VAR_W){1'b0}}, mn});
        write_reg(REG_INIT_VAR, {{(POS_W-VAR_W){1'b0}}, iv});
    endtask

    task automatic send_position(input pos_t x, input pos_t y);
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 45)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x <= x;
        pos_y <= y;
        do
            @(posedge clk);
        while (in_stall);
        if (smooth_on)
            smoothed++;
        expected_fixes.insert(expected_fixes.size(), track_fix(x, y));
        positions_sent++;
    endtask

    task automatic wait_until_settled();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_fixes.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_fixes.size() == 0)
            begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("Unexpected result transfer: north %0d east %0d",
                             $signed(north), $signed(east));
            end
            else
            begin
                want_fix = expected_fixes.pop_front();
                fixes_checked++;
                if (north !== want_fix.north || east !== want_fix.east)
                begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("Result %0d: north exp %0d got %0d, east exp %0d got %0d",
                                 fixes_checked, $signed(want_fix.north), $signed(north),
                                 $signed(want_fix.east), $signed(east));
                end
            end
        end
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    function automatic var_t random_noise();
        return var_t'($urandom) & ((var_t'(1) << $urandom_range(0, VAR_W)) - var_t'(1));
    endfunction

    function automatic pos_t random_coord(input pos_t center);
        case ($urandom_range(9))
            0, 1, 2: return pos_t'($urandom);
            3:       return $urandom_range(1) ? POS_HI : POS_LO;
            default: return center + pos_t'(int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
        endcase
    endfunction

    function automatic pos_t random_origin();
        if ($urandom_range(1))
            return pos_t'($urandom);
        return pos_t'(int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
    endfunction

    task automatic randomize_config();
        coef_t c;
        coef_t s;
        if ($urandom_range(4) == 0)
        begin
            c = coef_t'($urandom);
            s = coef_t'($urandom);
        end
        else
        begin
            c = coef_t'(int'($urandom_range(0, 32768)) - 16384);
            s = coef_t'(int'($urandom_range(0, 32768)) - 16384);
        end
        set_all($urandom_range(3) != 0, c, s, random_origin(), random_origin(),
                random_noise(), random_noise(), random_noise());
    endtask

    task automatic test_reset_defaults();
        send_position('0, '0);
        send_position(POS_HI, POS_LO);
        send_position(POS_LO, POS_HI);
        send_position(-1, -1);
        send_position(POS_HI, POS_HI);
        wait_until_settled();
    endtask

    task automatic test_rotation_passthrough();
        set_all(1'b0, coef_t'(0), coef_t'(16384), '0, '0,
                PROC_NOISE_RESET, MEAS_NOISE_RESET, INIT_VAR_RESET);
        send_position(pos_t'(65536), '0);
        send_position('0, pos_t'(65536));
        wait_until_settled();
        set_all(1'b0, coef_t'(-16384), coef_t'(0), POS_LO, POS_HI,
                PROC_NOISE_RESET, MEAS_NOISE_RESET, INIT_VAR_RESET);
        send_position(POS_HI, POS_LO);
        send_position(POS_LO, POS_HI);
        wait_until_settled();
        set_all(1'b0, coef_t'(16'h8000), coef_t'(16'h7fff), '0, '0,
                PROC_NOISE_RESET, MEAS_NOISE_RESET, INIT_VAR_RESET);
        send_position(POS_HI, POS_HI);
        send_position(POS_LO, pos_t'(1));
        wait_until_settled();
    endtask

    task automatic test_noise_extremes();
        set_all(1'b1, COS_RESET, coef_t'(0), '0, '0, '0, '0, VAR_MAX);
        send_position(pos_t'(32'h0123_4567), pos_t'(-32'sh0765_4321));
        send_position(POS_HI, POS_LO);
        send_position(pos_t'(5), pos_t'(-5));
        wait_until_settled();
        set_all(1'b1, coef_t'(-16384), coef_t'(16384), '0, '0, VAR_MAX, '0, '0);
        send_position(POS_LO, POS_LO);
        send_position(pos_t'(12345), pos_t'(-98765));
        wait_until_settled();
        set_all(1'b1, COS_RESET, coef_t'(0), POS_HI, POS_LO, VAR_MAX, VAR_MAX, VAR_MAX);
        send_position(POS_LO, POS_HI);
        send_position('0, '0);
        wait_until_settled();
        set_all(1'b1, COS_RESET, coef_t'(0), '0, '0, '0, VAR_MAX, INIT_VAR_RESET);
        send_position(POS_HI, POS_HI);
        send_position(pos_t'(-65536), pos_t'(65536));
        wait_until_settled();
    endtask

    task automatic test_random_traffic(input int n_items, input int src_pct, input int sink_pct);
        int left;
        int burst;
        src_idle_pct = src_pct;
        sink_stall_pct = sink_pct;
        left = n_items;
        while (left > 0)
        begin
            randomize_config();
            burst = $urandom_range(15, 50);
            if (burst > left)
                burst = left;
            repeat (burst) send_position(random_coord(origin_x_r), random_coord(origin_y_r));
            left -= burst;
            wait_until_settled();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_rotation_passthrough();
        test_noise_extremes();
        test_random_traffic(367, 32, 79);
        test_random_traffic(367, 79, 32);
        test_random_traffic(366, 0, 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_fixes.size() != 0)
        begin
            errors += expected_fixes.size();
            $display("%0d expected results never arrived", expected_fixes.size());
        end
        $display("Sent %0d positions (%0d smoothed, the rest passed through) over %0d register writes.",
                 positions_sent, smoothed, reg_writes);
        $display("Compared %0d results, %0d mismatches.", fixes_checked, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("Timeout with %0d results outstanding.", expected_fixes.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/rokp_pkg.sv
rtl/core/rotate_offset_kalman_position.sv
bench/tb_rotate_offset_kalman_position.sv
